// File: design/emhq_pkg.sv
// ----------------------------------------------------------------------------
// emhq_pkg
// Shared types and constants of the event min-heap queue: request and
// response payloads, heap entry layout, operation and status codes, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package emhq_pkg;

  // Default heap depth and fixed field widths
  localparam int CAPACITY_DEF = 1024;
  localparam int TIME_BITS    = 32;
  localparam int TIME_W       = 32;
  localparam int JOB_W        = 32;
  localparam int KIND_W       = 2;
  localparam int STATION_W    = 12;
  localparam int OCC_W        = 11;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic [TIME_BITS-1:0] key_t;

  // Request payload
  typedef struct packed {
    func_e                 func;
    logic [TIME_W-1:0]     event_time;
    logic [JOB_W-1:0]      job_number;
    logic [KIND_W-1:0]     event_kind;
    logic [STATION_W-1:0]  station;
  } req_t;

  // Response payload
  typedef struct packed {
    logic                  popped_valid;
    logic [TIME_W-1:0]     popped_time;
    logic [JOB_W-1:0]      popped_job;
    logic [KIND_W-1:0]     popped_kind;
    logic [STATION_W-1:0]  popped_station;
    status_e               status;
    logic [OCC_W-1:0]      occupancy;
  } rsp_t;

  // One heap slot
  typedef struct packed {
    key_t                  key;
    logic [JOB_W-1:0]      job;
    logic [KIND_W-1:0]     kind;
    logic [STATION_W-1:0]  station;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;      // capture request, set up result and count
    logic rd_parent;  // read parent of current hole
    logic move_up;    // parent into hole, hole climbs
    logic rd_pop;     // read root and last entry, shrink count
    logic take;       // root into result, last entry becomes moving item
    logic rd_kids;    // read both children of current hole
    logic move_down;  // smaller child into hole, hole descends
    logic place;      // moving item into hole, sift ends
    logic emit;       // result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_op;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_swap;
    logic down_move;
  } sts_t;

endpackage

// File: design/emhq_dp.sv
// ----------------------------------------------------------------------------
// emhq_dp
// Heap datapath: entry memory with one write and two registered read ports,
// entry count, hole position, moving item, key compares and result staging.
// ----------------------------------------------------------------------------
module emhq_dp import emhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  entry_t          mem [CAPACITY];
  logic [CW-1:0]   count;
  logic [AW-1:0]   pos;
  entry_t          held;
  entry_t          q0;
  logic [AW-1:0]   ra0;
  logic [AW-1:0]   ra1;
  logic [AW-1:0]   up;
  logic [CW-1:0]   last_idx;
  entry_t          q1;
  rsp_t            res;
  rsp_t            res_init;
  rsp_t            rsp_out;

  logic [IW-1:0]   lidx;
  logic [IW-1:0]   ridx;
  logic [IW-1:0]   cnt_x;
  logic            l_less;
  logic            r_less;
  key_t            best_key;
  entry_t          child;
  entry_t          wdata;
  logic            we;
  logic            re;

  // Heap index arithmetic
  assign up       = AW'((pos - AW'(1)) >> 1);
  assign lidx     = IW'({pos, 1'b1});
  assign ridx     = lidx + IW'(1);
  assign cnt_x    = IW'(count);
  assign last_idx = count - CW'(1);

  // Sift-down choice: left first, right only if strictly smaller still
  assign l_less   = (lidx < cnt_x) && (q0.key < held.key);
  assign best_key = l_less ? q0.key : held.key;
  assign r_less   = (ridx < cnt_x) && (q1.key < best_key);
  assign child    = r_less ? q1 : q0;

  // Status towards the controller
  assign sts.pop_op    = (req.func == FUNC_POP);
  assign sts.full      = (count == CW'(CAPACITY));
  assign sts.empty     = (count == '0);
  assign sts.pos_zero  = (pos == '0);
  assign sts.up_swap   = (q0.key > held.key);
  assign sts.down_move = l_less || r_less;

  // Select memory addresses and write data
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    if (cmd.rd_parent) begin
      ra0 = up;
    end else if (cmd.rd_pop) begin
      ra1 = last_idx[AW-1:0];
    end else if (cmd.rd_kids) begin
      ra0 = lidx[AW-1:0];
      ra1 = ridx[AW-1:0];
    end
  end

  assign re = cmd.rd_parent | cmd.rd_pop | cmd.rd_kids;
  assign we = cmd.place | cmd.move_up | cmd.move_down;

  always_comb begin
    wdata = held;
    if (cmd.move_up) begin
      wdata = q0;
    end else if (cmd.move_down) begin
      wdata = child;
    end
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= wdata;
    end
    if (re) begin
      q0 <= mem[ra0];
      q1 <= mem[ra1];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start && !sts.pop_op && !sts.full) begin
      count <= count + CW'(1);
    end else if (cmd.rd_pop) begin
      count <= last_idx;
    end
  end

  // Hole position and moving item
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos  <= count[AW-1:0];
      held <= '{key: req.event_time[TIME_BITS-1:0], job: req.job_number,
                kind: req.event_kind, station: req.station};
    end else if (cmd.take) begin
      pos  <= '0;
      held <= q1;
    end else if (cmd.move_up) begin
      pos  <= up;
    end else if (cmd.move_down) begin
      pos  <= r_less ? ridx[AW-1:0] : lidx[AW-1:0];
    end
  end

  // Result at the start of a request: status only, event fields cleared
  always_comb begin
    res_init = '0;
    if (sts.pop_op) begin
      res_init.status = sts.empty ? ST_EMPTY : ST_OK;
    end else begin
      res_init.status = sts.full ? ST_FULL : ST_OK;
    end
  end

  // Staged result with the current entry count
  always_comb begin
    rsp_out           = res;
    rsp_out.occupancy = OCC_W'(count);
  end

  // Stage the result, then hand it to the output register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res <= res_init;
    end else if (cmd.take) begin
      res.popped_valid   <= 1'b1;
      res.popped_time    <= TIME_W'(q0.key);
      res.popped_job     <= q0.job;
      res.popped_kind    <= q0.kind;
      res.popped_station <= q0.station;
    end
    if (cmd.emit) begin
      rsp <= rsp_out;
    end
  end

endmodule

// File: design/emhq_ctrl.sv
// ----------------------------------------------------------------------------
// emhq_ctrl
// Sequencer of the heap: takes one request, walks the sift loop through
// read and compare steps, and loads the output register when it is free.
// ----------------------------------------------------------------------------
module emhq_ctrl import emhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UP_RD    = 8'b0000_0010,
    S_UP_CMP   = 8'b0000_0100,
    S_POP_RD   = 8'b0000_1000,
    S_POP_TAKE = 8'b0001_0000,
    S_DN_RD    = 8'b0010_0000,
    S_DN_CMP   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          if (sts.pop_op) begin
            state_next = sts.empty ? S_DONE : S_POP_RD;
          end else begin
            state_next = sts.full ? S_DONE : S_UP_RD;
          end
        end
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_swap) begin
          cmd.move_up = 1'b1;
          state_next  = S_UP_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_POP_RD: begin
        cmd.rd_pop = 1'b1;
        state_next = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        cmd.take   = 1'b1;
        state_next = sts.empty ? S_DONE : S_DN_RD;
      end
      S_DN_RD: begin
        cmd.rd_kids = 1'b1;
        state_next  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.down_move) begin
          cmd.move_down = 1'b1;
          state_next    = S_DN_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on load, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// File: design/event_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// event_min_heap_queue_top
// Binary min-heap of timed events with push and pop requests.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_t  (func, time, job, ...)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_t  (popped event, status)
//
// A push reads the parent of the hole and moves it down while its key is
// greater, then places the new entry; a pop reads the root and the last
// entry, takes the root and sifts the last entry down. A dropped push or an
// empty pop goes straight to the done state. Each level is a registered
// memory read then a compare and one write on the single write port; the
// two read ports fetch both children. Reset clears the entry count, the
// state and the output valid only; the memory is not swept. A request is
// taken while a previous result still waits in the output register; a
// stalled output holds the block only when the next result is ready.
// ----------------------------------------------------------------------------
module event_min_heap_queue_top import emhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  emhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  emhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

  // The block is not ready again in the cycle after taking a request
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken on consecutive cycles");

  // A returned event always reports success
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.popped_valid) |-> (rsp.status == ST_OK))
    else $error("popped event with error status");

  // A dropped push leaves the heap full
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> (rsp.occupancy == OCC_W'(CAPACITY)))
    else $error("full status without full heap");

  // A pop on empty leaves the heap empty
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0 && !rsp.popped_valid))
    else $error("empty status with events held");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the event min-heap queue. A short table of push and
// pop requests covers extremes, ties, empty pops and the last-entry pop, then
// random traffic in three idle mixes with segments that grow, shrink or hold
// the heap. Every response is checked against a typed expectation or a heap model.
// ----------------------------------------------------------------------------
module tb_top;
  import emhq_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int CYCLE_MAX  = 1000000;
  localparam int RAND_ITEMS = 700;

  typedef struct {
    req_t item;
    bit   has_want;
    rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Heap model state
  entry_t heap_slot [0:CAP-1];
  int     heap_count;

  rsp_t   pending_results [$];
  row_t   plan [$];

  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int mismatches;
  int results_seen;
  int n_push, n_pop, n_full, n_empty, peak_occ;

  event_min_heap_queue_top #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Apply one request to the heap model and return the response it yields
  function automatic rsp_t heap_predict(req_t r);
    rsp_t   res;
    entry_t tmp;
    int     pos, up, lc, rc, best;
    bit     done;
    res = '0;
    res.status = ST_OK;
    if (r.func == FUNC_PUSH) begin
      if (heap_count >= CAP) begin
        res.status = ST_FULL;
      end else begin
        heap_slot[heap_count] = '{r.event_time, r.job_number, r.event_kind, r.station};
        pos = heap_count;
        heap_count++;
        done = 1'b0;
        // climb while the parent key is strictly greater
        while (pos > 0 && !done) begin
          up = (pos - 1) / 2;
          if (heap_slot[up].key > heap_slot[pos].key) begin
            tmp = heap_slot[up];
            heap_slot[up] = heap_slot[pos];
            heap_slot[pos] = tmp;
            pos = up;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else if (heap_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.popped_valid   = 1'b1;
      res.popped_time    = heap_slot[0].key;
      res.popped_job     = heap_slot[0].job;
      res.popped_kind    = heap_slot[0].kind;
      res.popped_station = heap_slot[0].station;
      heap_count--;
      if (heap_count > 0) begin
        heap_slot[0] = heap_slot[heap_count];
        pos = 0;
        done = 1'b0;
        // descend into the strictly smaller child, left checked first
        while (!done) begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          best = pos;
          if (lc < heap_count && heap_slot[lc].key < heap_slot[best].key) best = lc;
          if (rc < heap_count && heap_slot[rc].key < heap_slot[best].key) best = rc;
          if (best == pos) begin
            done = 1'b1;
          end else begin
            tmp = heap_slot[best];
            heap_slot[best] = heap_slot[pos];
            heap_slot[pos] = tmp;
            pos = best;
          end
        end
      end
    end
    res.occupancy = OCC_W'(heap_count);
    return res;
  endfunction

  // Key mix: extremes, a narrow band for ties, and the full range
  function automatic logic [TIME_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel < 6) return TIME_W'($urandom_range(15));
    return TIME_W'($urandom);
  endfunction

  function automatic req_t rand_request(func_e f);
    req_t r;
    r.func       = f;
    r.event_time = pick_key();
    r.job_number = $urandom;
    r.event_kind = KIND_W'($urandom_range(3));
    r.station    = STATION_W'($urandom);
    return r;
  endfunction

  function automatic void add_row(req_t r, bit has_want, rsp_t want);
    row_t e;
    e.item     = r;
    e.has_want = has_want;
    e.want     = want;
    plan.push_back(e);
  endfunction

  // Present one request, hold it until the transfer, then record the expectation
  task automatic send_event(req_t item, bit has_want, rsp_t want);
    rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pred = heap_predict(item);
    pending_results.push_back(has_want ? want : pred);
    if (item.func == FUNC_PUSH) n_push++;
    else n_pop++;
    if (pred.status == ST_FULL) n_full++;
    if (pred.status == ST_EMPTY) n_empty++;
    if (heap_count > peak_occ) peak_occ = heap_count;
  endtask

  // Random segments that grow, shrink or hold the heap level
  task automatic run_random(int n_items);
    int left, seg, mode, push_pct;
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(20, 60);
      if (seg > left) seg = left;
      mode = $urandom_range(2);
      push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      repeat (seg) begin
        if ($urandom_range(99) < push_pct)
          send_event(rand_request(FUNC_PUSH), 1'b0, '0);
        else
          send_event(rand_request(FUNC_POP), 1'b0, '0);
      end
      left -= seg;
    end
  endtask

  // Compare one response with the oldest expectation
  task automatic check_result(rsp_t got);
    rsp_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected response: valid=%0b time=%h job=%h kind=%0d stn=%h st=%0d occ=%0d",
                 got.popped_valid, got.popped_time, got.popped_job, got.popped_kind,
                 got.popped_station, got.status, got.occupancy);
    end else begin
      want = pending_results.pop_front();
      if (got.popped_valid !== want.popped_valid || got.popped_time !== want.popped_time ||
          got.popped_job !== want.popped_job || got.popped_kind !== want.popped_kind ||
          got.popped_station !== want.popped_station || got.status !== want.status ||
          got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on response %0d:", results_seen);
          $display("  expected valid=%0b time=%h job=%h kind=%0d stn=%h st=%0d occ=%0d",
                   want.popped_valid, want.popped_time, want.popped_job, want.popped_kind,
                   want.popped_station, want.status, want.occupancy);
          $display("  actual   valid=%0b time=%h job=%h kind=%0d stn=%h st=%0d occ=%0d",
                   got.popped_valid, got.popped_time, got.popped_job, got.popped_kind,
                   got.popped_station, got.status, got.occupancy);
        end
      end
    end
  endtask

  // Sample responses and stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) check_result(rsp);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_MAX);
    $display("timeout after %0d cycles, %0d responses outstanding",
             cycle_count, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    heap_count    = 0;
    mismatches    = 0;
    results_seen  = 0;
    n_push        = 0;
    n_pop         = 0;
    n_full        = 0;
    n_empty       = 0;
    peak_occ      = 0;
    send_idle_pct = 36;
    recv_idle_pct = 47;

    // Directed table: typed expectations where obvious, model elsewhere
    add_row('{FUNC_POP, '0, '0, 2'd0, '0}, 1'b1,
            '{1'b0, '0, '0, 2'd0, '0, ST_EMPTY, 11'd0});
    add_row('{FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 12'hFFF}, 1'b1,
            '{1'b0, '0, '0, 2'd0, '0, ST_OK, 11'd1});
    add_row('{FUNC_POP, '0, '0, 2'd0, '0}, 1'b1,
            '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 12'hFFF, ST_OK, 11'd0});
    add_row('{FUNC_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 12'hFFF}, 1'b1,
            '{1'b0, '0, '0, 2'd0, '0, ST_EMPTY, 11'd0});
    add_row('{FUNC_PUSH, 32'd0, 32'd0, 2'd0, 12'd0}, 1'b1,
            '{1'b0, '0, '0, 2'd0, '0, ST_OK, 11'd1});
    add_row('{FUNC_PUSH, 32'd100, 32'd1, 2'd1, 12'd1}, 1'b0, '0);
    add_row('{FUNC_PUSH, 32'd50, 32'd2, 2'd2, 12'hFFF}, 1'b0, '0);
    add_row('{FUNC_PUSH, 32'd50, 32'd3, 2'd0, 12'd3}, 1'b0, '0);
    add_row('{FUNC_PUSH, 32'd50, 32'd4, 2'd1, 12'd4}, 1'b0, '0);
    add_row('{FUNC_PUSH, 32'd7, 32'd5, 2'd2, 12'd5}, 1'b0, '0);
    add_row('{FUNC_PUSH, 32'd100, 32'd6, 2'd3, 12'd6}, 1'b0, '0);
    add_row('{FUNC_PUSH, 32'hFFFF_FFFF, 32'd7, 2'd3, 12'h800}, 1'b0, '0);
    add_row('{FUNC_PUSH, 32'd0, 32'd8, 2'd1, 12'h7FF}, 1'b0, '0);
    repeat (9) add_row('{FUNC_POP, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 2'd2, 12'hA5A}, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase A: sender idles 36 in 100, receiver 47 in 100
    foreach (plan[i]) send_event(plan[i].item, plan[i].has_want, plan[i].want);
    run_random(RAND_ITEMS / 3);

    // Phase B: idle rates swapped
    send_idle_pct = 47;
    recv_idle_pct = 36;
    run_random(RAND_ITEMS / 3);

    // Phase C: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
    req_valid <= 1'b0;

    // Let outstanding responses arrive, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d pushes (%0d dropped on a full heap) and %0d pops (%0d on empty).",
             n_push, n_full, n_pop, n_empty);
    $display("Peak occupancy %0d of %0d, %0d responses checked, %0d mismatches.",
             peak_occ, CAP, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/emhq_pkg.sv
design/emhq_dp.sv
design/emhq_ctrl.sv
design/event_min_heap_queue_top.sv
dv/tb_top.sv
